[design/assert_macros.svh]
// Assertion macros shared by the ordered array table RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define OAT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define OAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/oat_pkg.sv]
// Package for the ordered array table: sizes, command and status codes,
// payload structs and the per-cell control struct. No dependencies.
package oat_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 5;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_SET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_SEARCH = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_UP    = 2'd2,
    CELL_DOWN  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     in_use;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [IDX_W-1:0]   found_position;
    logic [CNT_W-1:0]   count;
    logic               empty_res;
  } out_t;

  // Sign-extend a stored word to the 32-bit result field.
  function automatic logic [31:0] word_to_field(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] ext;
    ext = 64'(signed'(w));
    return ext[31:0];
  endfunction

endpackage

[design/ordered_array_table.sv]
// Ordered array table: a list of up to DEPTH signed words held in a chain of
// cells. A command is taken in the same cycle it is offered whenever the
// result register is empty or its result is taken in that cycle, so the
// block sustains one command per clock; the result appears in the cycle
// after the transfer. Insert and remove move every later entry together by
// having each cell take its neighbor's word, and a search compares all live
// cells at once and picks the lowest matching position.
// Depends on oat_pkg, oat_cell and assert_macros.svh.
`include "assert_macros.svh"

module ordered_array_table
  import oat_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic                  in_fire;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_t                  out_data_r;
  out_t                  out_data_nxt;
  logic [DATA_WIDTH-1:0] wval;
  logic [DATA_WIDTH-1:0] words   [DEPTH];
  logic [DATA_WIDTH-1:0] lower_w [DEPTH];
  logic [DATA_WIDTH-1:0] upper_w [DEPTH];
  cell_op_e              op_v    [DEPTH];
  cell_ctl_t             ctl     [DEPTH];
  logic [DEPTH-1:0]      match;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign wval      = in_data.value[DATA_WIDTH-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic full;
    logic in_range;
    full              = (count_r == CNT_W'(DEPTH));
    in_range          = (in_data.position < count_r);
    count_nxt         = count_r;
    out_data_nxt      = '0;
    out_data_nxt.status = ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      op_v[i] = CELL_HOLD;
    end
    case (cmd_e'(in_data.cmd))
      CMD_APPEND: begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == count_r) op_v[i] = CELL_LOAD;
          end
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (in_data.position > count_r) begin
          out_data_nxt.status = ST_RANGE;
        end else if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == in_data.position) begin
              op_v[i] = CELL_LOAD;
            end else if (CNT_W'(i) > in_data.position && CNT_W'(i) <= count_r) begin
              op_v[i] = CELL_UP;
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_SET: begin
        if (!in_range) begin
          out_data_nxt.status = ST_RANGE;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == in_data.position) op_v[i] = CELL_LOAD;
          end
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          out_data_nxt.status = ST_RANGE;
        end else begin
          out_data_nxt.read_value = word_to_field(words[in_data.position[IDX_W-1:0]]);
          // close the gap; the top cell keeps its stale word
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (CNT_W'(i) >= in_data.position) op_v[i] = CELL_DOWN;
          end
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_GET: begin
        if (!in_range) begin
          out_data_nxt.status = ST_RANGE;
        end else begin
          out_data_nxt.read_value = word_to_field(words[in_data.position[IDX_W-1:0]]);
        end
      end
      CMD_SEARCH: begin
        if (match == '0) begin
          out_data_nxt.status = ST_MISS;
        end else begin
          for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) out_data_nxt.found_position = IDX_W'(i);
          end
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    out_data_nxt.count     = count_nxt;
    out_data_nxt.empty_res = (count_nxt == '0);
    if (!in_fire) begin
      count_nxt = count_r;
      for (int i = 0; i < DEPTH; i++) begin
        op_v[i] = CELL_HOLD;
      end
    end
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_low
      assign lower_w[g] = wval;
    end else begin : g_low
      assign lower_w[g] = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_up
      assign upper_w[g] = words[g];
    end else begin : g_up
      assign upper_w[g] = words[g+1];
    end
    assign ctl[g] = '{op: op_v[g], in_use: (CNT_W'(g) < count_r)};

    oat_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .load_word  (wval),
      .lower_word (lower_w[g]),
      .upper_word (upper_w[g]),
      .word       (words[g]),
      .match      (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  `OAT_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count above capacity")
  `OAT_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r && out_data_r.count == count_r, "transfer without matching result")
  `OAT_ASSERT(a_empty_flag, !out_valid_r || (out_data_r.empty_res == (out_data_r.count == '0)), "empty flag disagrees with count")
  `OAT_ASSERT_NEXT(a_clear_empties, in_fire && in_data.cmd == CMD_CLEAR, count_r == '0, "clear left entries")

endmodule

[design/oat_cell.sv]
// One entry of the ordered array table: a word register that loads, takes
// its lower or upper neighbor's word, or holds. Depends on oat_pkg.
module oat_cell
  import oat_pkg::*;
(
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] lower_word,
  input  logic [DATA_WIDTH-1:0] upper_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    case (ctl.op)
      CELL_LOAD: word_nxt = load_word;
      CELL_UP:   word_nxt = lower_word;
      CELL_DOWN: word_nxt = upper_word;
      default:   word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word  = word_r;
  // only live entries may answer a search
  assign match = ctl.in_use && (word_r == load_word);

endmodule
